### hdl/chbs_pkg.sv
// Shared types, constants and codes for the chained hash bucket store.
`timescale 1ns / 1ps

package chbs_pkg;

    // Field widths of the stream beats.
    localparam int KEY_W      = 31;
    localparam int CMD_W      = 2;
    localparam int BKT_IN_W   = 6;
    localparam int MOD_W      = 7;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 32;

    // Largest divisor that the modulus register can express.
    localparam int MOD_MAX    = (1 << MOD_W) - 1;

    // Default sizes of the bucket table and of the node pool.
    localparam int BUCKETS_DEF = 64;
    localparam int NODES_DEF   = 64;

    // Modulus after reset.
    localparam logic [MOD_W-1:0] MODULUS_RST = 7'd64;

    // Width of the divider step counter.
    localparam int DIV_CNT_W = $clog2(KEY_W + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_LIST   = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_OOB   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV,
        ST_INS_WR,
        ST_LIST_HEAD,
        ST_WALK,
        ST_RESP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    clear;
        logic    div_start;
        logic    div_step;
        logic    bkt_rd;
        logic    ins_wr;
        logic    walk_start;
        logic    walk_emit;
        logic    resp_emit;
        status_t resp_status;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             bkt_oob;
        logic             bkt_valid;
        logic             div_done;
        logic             out_free;
        logic             walk_last;
    } dp_stat_t;

endpackage

### hdl/chained_hash_bucket_store_core.sv
// Top level of the chained hash bucket store: controller, datapath and checks.
`timescale 1ns / 1ps

// Separate-chaining hash store. Each input beat carries a command in s_tuser: insert
// appends the key to the tail of bucket (key mod modulus), list returns the keys of one
// bucket in insertion order with m_tlast on the final one, clear empties the table and
// the node pool. Every insert, clear and failed list returns one beat; the status in
// m_tuser reports a full pool, an empty bucket or a bucket index not below the modulus.
// Command code 3 is dropped without a result. The modulus register (cfg_wr_en,
// cfg_wr_data) is clamped to 1..min(BUCKETS, 127). The user must write it only while the
// block is idle; the block itself does not enforce this. Keys already stored stay in the
// bucket they were hashed to. One command is processed at a time. An insert's result waits
// on the bit-serial remainder unit, which takes one of the 31 key bits per cycle; a
// pool-full insert, a clear or a failed list skip that unit. A list of N keys delivers
// its keys one per cycle while m_tready stays high, paced by the registered read of the
// node memories.
// The table clears at once on reset, so no clearing pass follows it.

module chained_hash_bucket_store_core import chbs_pkg::*; #(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int NODES   = NODES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [MOD_W-1:0]     cfg_wr_data,    // modulus
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,        // key [30:0], bucket [36:31], zero pad
    input  logic [CMD_W-1:0]     s_tuser,        // cmd [1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,        // out_key [30:0], zero pad
    output logic [STATUS_W-1:0]  m_tuser,        // status [1:0]
    output logic                 m_tlast
);

    ctrl_cmd_t ctrl;
    dp_stat_t  stat;

    chbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (ctrl)
    );

    chbs_dp #(.BUCKETS(BUCKETS), .NODES(NODES)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .ctrl        (ctrl),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // A new beat is loaded into the output register only when the register is free.
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.resp_emit || ctrl.walk_emit) |-> stat.out_free)
        else $error("result loaded over an untaken beat");

    // The single-beat result and the chain walk never load the output together.
    a_emit_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctrl.resp_emit && ctrl.walk_emit))
        else $error("two result sources in one cycle");

    // Any non-ok status ends its command.
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != STAT_OK)) |-> m_tlast)
        else $error("error status without last");

    // After a command is accepted, no further beat is taken until it completes.
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second command accepted while busy");

endmodule

### hdl/chbs_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module chbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                 aclk,
    input  logic                                 wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic                                 rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/chbs_ctrl.sv
// Controller state machine that sequences insert, list and clear commands.
`timescale 1ns / 1ps

module chbs_ctrl import chbs_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    state_t  state_reg, state_next;
    status_t resp_code_reg, resp_code_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            resp_code_reg <= STAT_OK;
        end else begin
            state_reg     <= state_next;
            resp_code_reg <= resp_code_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        resp_code_next = resp_code_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (stat.cmd)
                    CMD_INSERT: begin
                        if (stat.full) begin
                            resp_code_next = STAT_FULL;
                            state_next     = ST_RESP;
                        end else begin
                            state_next = ST_DIV;
                        end
                    end
                    CMD_LIST: begin
                        if (stat.bkt_oob) begin
                            resp_code_next = STAT_OOB;
                            state_next     = ST_RESP;
                        end else if (!stat.bkt_valid) begin
                            resp_code_next = STAT_EMPTY;
                            state_next     = ST_RESP;
                        end else begin
                            state_next = ST_LIST_HEAD;
                        end
                    end
                    CMD_CLEAR: begin
                        resp_code_next = STAT_OK;
                        state_next     = ST_RESP;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_DIV: begin
                if (stat.div_done) begin
                    state_next = ST_INS_WR;
                end
            end
            ST_INS_WR: begin
                resp_code_next = STAT_OK;
                state_next     = ST_RESP;
            end
            ST_LIST_HEAD: begin
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (stat.out_free && stat.walk_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_RESP: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd             = '0;
        cmd.resp_status = resp_code_reg;
        s_tready        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_DECODE: begin
                cmd.div_start = (stat.cmd == CMD_INSERT) && !stat.full;
                cmd.bkt_rd    = (stat.cmd == CMD_LIST) && !stat.bkt_oob && stat.bkt_valid;
                cmd.clear     = (stat.cmd == CMD_CLEAR);
            end
            ST_DIV: begin
                cmd.div_step = !stat.div_done;
                cmd.bkt_rd   = stat.div_done;
            end
            ST_INS_WR: begin
                cmd.ins_wr = 1'b1;
            end
            ST_LIST_HEAD: begin
                cmd.walk_start = 1'b1;
            end
            ST_WALK: begin
                cmd.walk_emit = stat.out_free;
            end
            ST_RESP: begin
                cmd.resp_emit = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

### hdl/chbs_dp.sv
// Datapath: command latch, serial modulo unit, bucket and node memories, output register.
`timescale 1ns / 1ps

module chbs_dp import chbs_pkg::*; #(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int NODES   = NODES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [MOD_W-1:0]      cfg_wr_data,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [CMD_W-1:0]      s_tuser,
    input  ctrl_cmd_t             ctrl,
    output dp_stat_t              stat,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic [STATUS_W-1:0]   m_tuser,
    output logic                  m_tlast
);

    // Only buckets below the largest reachable divisor are ever addressed.
    localparam int M_MAX = (BUCKETS > MOD_MAX) ? MOD_MAX : BUCKETS;
    localparam int BI_W  = (M_MAX > 1) ? $clog2(M_MAX) : 1;
    localparam int NW    = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int NU_W  = NW + 1;
    localparam logic [MOD_W-1:0] M_MAX_V = MOD_W'(M_MAX);
    localparam logic [NU_W-1:0]  NODES_V = NU_W'(NODES);

    logic [MOD_W-1:0]     modulus_reg;
    logic [MOD_W-1:0]     m_eff;
    logic [CMD_W-1:0]     cmd_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [BKT_IN_W-1:0]  bucket_reg;
    logic [KEY_W-1:0]     div_q_reg;
    logic [MOD_W-1:0]     rem_reg;
    logic [MOD_W-1:0]     rem_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [MOD_W:0]       trial;
    logic [M_MAX-1:0]     head_valid_reg;
    logic [NU_W-1:0]      nodes_used_reg;
    logic [NW-1:0]        new_n;
    logic [NW-1:0]        ptr_reg;
    logic [NW-1:0]        tail_reg;
    logic [BI_W-1:0]      list_idx;
    logic [BI_W-1:0]      hash_idx;
    logic [BI_W-1:0]      bkt_idx;
    logic                 hash_valid;
    logic [2*NW-1:0]      bkt_wr_data;
    logic [2*NW-1:0]      bkt_rd_data;
    logic [NW-1:0]        bkt_head_rd;
    logic [NW-1:0]        bkt_tail_rd;
    logic [KEY_W-1:0]     key_rd;
    logic [NW-1:0]        next_rd;
    logic [NW-1:0]        node_rd_addr;
    logic                 node_rd_en;
    logic                 walk_last;
    logic                 out_free;
    logic                 m_tvalid_reg;
    logic [KEY_W-1:0]     out_key_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic                 out_last_reg;

    // Divisor clamped to 1..M_MAX.
    always_comb begin
        if (modulus_reg == '0) begin
            m_eff = MOD_W'(1);
        end else if (modulus_reg > M_MAX_V) begin
            m_eff = M_MAX_V;
        end else begin
            m_eff = modulus_reg;
        end
    end

    assign list_idx    = BI_W'(bucket_reg);
    assign hash_idx    = BI_W'(rem_reg);
    assign bkt_idx     = (cmd_reg == CMD_LIST) ? list_idx : hash_idx;
    assign hash_valid  = head_valid_reg[hash_idx];
    assign new_n       = nodes_used_reg[NW-1:0];
    assign bkt_head_rd = bkt_rd_data[2*NW-1:NW];
    assign bkt_tail_rd = bkt_rd_data[NW-1:0];
    assign walk_last   = (ptr_reg == tail_reg);
    assign out_free    = !m_tvalid_reg || m_tready;

    // One restoring step of the remainder per cycle, most significant key bit first.
    assign trial    = {rem_reg, div_q_reg[KEY_W-1]};
    assign rem_next = (trial >= {1'b0, m_eff}) ? MOD_W'(trial - {1'b0, m_eff})
                                               : trial[MOD_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg    <= MODULUS_RST;
            head_valid_reg <= '0;
            nodes_used_reg <= '0;
            div_cnt_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                modulus_reg <= cfg_wr_data;
            end
            if (ctrl.clear) begin
                head_valid_reg <= '0;
                nodes_used_reg <= '0;
            end else if (ctrl.ins_wr) begin
                head_valid_reg[hash_idx] <= 1'b1;
                nodes_used_reg           <= nodes_used_reg + NU_W'(1);
            end
            if (ctrl.div_start) begin
                div_cnt_reg <= '0;
            end else if (ctrl.div_step) begin
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            end
            if (ctrl.resp_emit || ctrl.walk_emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            cmd_reg    <= s_tuser;
            key_reg    <= s_tdata[KEY_W-1:0];
            bucket_reg <= s_tdata[KEY_W +: BKT_IN_W];
        end
        if (ctrl.div_start) begin
            div_q_reg <= key_reg;
            rem_reg   <= '0;
        end else if (ctrl.div_step) begin
            div_q_reg <= {div_q_reg[KEY_W-2:0], 1'b0};
            rem_reg   <= rem_next;
        end
        if (ctrl.walk_start) begin
            ptr_reg  <= bkt_head_rd;
            tail_reg <= bkt_tail_rd;
        end else if (ctrl.walk_emit && !walk_last) begin
            ptr_reg <= next_rd;
        end
        if (ctrl.resp_emit) begin
            out_key_reg    <= '0;
            out_status_reg <= ctrl.resp_status;
            out_last_reg   <= 1'b1;
        end else if (ctrl.walk_emit) begin
            out_key_reg    <= key_rd;
            out_status_reg <= STAT_OK;
            out_last_reg   <= walk_last;
        end
    end

    // Appending keeps the head of a live chain and moves its tail to the new node.
    assign bkt_wr_data = hash_valid ? {bkt_head_rd, new_n} : {new_n, new_n};

    chbs_ram #(.WIDTH(2 * NW), .DEPTH(M_MAX)) u_bkt_ram (
        .aclk    (aclk),
        .wr_en   (ctrl.ins_wr),
        .wr_addr (hash_idx),
        .wr_data (bkt_wr_data),
        .rd_en   (ctrl.bkt_rd),
        .rd_addr (bkt_idx),
        .rd_data (bkt_rd_data)
    );

    assign node_rd_en   = ctrl.walk_start || (ctrl.walk_emit && !walk_last);
    assign node_rd_addr = ctrl.walk_start ? bkt_head_rd : next_rd;

    chbs_ram #(.WIDTH(KEY_W), .DEPTH(NODES)) u_key_ram (
        .aclk    (aclk),
        .wr_en   (ctrl.ins_wr),
        .wr_addr (new_n),
        .wr_data (key_reg),
        .rd_en   (node_rd_en),
        .rd_addr (node_rd_addr),
        .rd_data (key_rd)
    );

    // The link of the new tail is never followed, so only the old tail is written.
    chbs_ram #(.WIDTH(NW), .DEPTH(NODES)) u_next_ram (
        .aclk    (aclk),
        .wr_en   (ctrl.ins_wr && hash_valid),
        .wr_addr (bkt_tail_rd),
        .wr_data (new_n),
        .rd_en   (node_rd_en),
        .rd_addr (node_rd_addr),
        .rd_data (next_rd)
    );

    always_comb begin
        stat.cmd       = cmd_reg;
        stat.full      = (nodes_used_reg >= NODES_V);
        stat.bkt_oob   = (MOD_W'(bucket_reg) >= m_eff);
        stat.bkt_valid = head_valid_reg[list_idx];
        stat.div_done  = (div_cnt_reg == DIV_CNT_W'(KEY_W));
        stat.out_free  = out_free;
        stat.walk_last = walk_last;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - KEY_W){1'b0}}, out_key_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule
